>>> src/dbwc_pkg.sv
// Shared types and constants for the disc/box wall collision block.
// No dependencies; imported by every module of the block.
`default_nettype none

package dbwc_pkg;

  // geometry width: edges, gap ends and clamped points of the walls
  localparam int unsigned CW = 36;
  // width of intermediate velocity terms before saturation
  localparam int unsigned VW = 40;

  localparam int unsigned MIN_WALL_LEN = 66;
  localparam int unsigned Q15_ONE      = 32768;

  localparam logic [2:0]  GAP_SIDE_RST = 3'd4;
  localparam logic [16:0] GAP_POS_RST  = 17'd32768;
  localparam logic [15:0] BOUNCE_RST   = 16'd16384;

  typedef enum logic [2:0] {
    REG_BOX_LEFT   = 3'd0,
    REG_BOX_TOP    = 3'd1,
    REG_BOX_WIDTH  = 3'd2,
    REG_BOX_HEIGHT = 3'd3,
    REG_GAP_SIDE   = 3'd4,
    REG_GAP_POS    = 3'd5,
    REG_GAP_WIDTH  = 3'd6,
    REG_BOUNCE     = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SIDE_TOP    = 2'd0,
    SIDE_BOTTOM = 2'd1,
    SIDE_LEFT   = 2'd2,
    SIDE_RIGHT  = 2'd3
  } side_e;

  typedef struct packed {
    logic signed [31:0] box_left;
    logic signed [31:0] box_top;
    logic signed [31:0] box_width;
    logic signed [31:0] box_height;
    logic [2:0]         gap_side;
    logic [16:0]        gap_position;
    logic [30:0]        gap_width;
  } dbwc_cfg_t;

  // bit 2*s is the first piece of side s, bit 2*s+1 the piece after the gap
  typedef struct packed {
    logic signed [CW-1:0] xr;
    logic signed [CW-1:0] yb;
    logic signed [CW-1:0] gmin;
    logic signed [CW-1:0] gmax;
    logic [7:0]           mask;
  } dbwc_geom_t;

  typedef struct packed {
    logic start;
    logic div;
  } dbwc_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dbwc_stat_t;

endpackage

`default_nettype wire

>>> src/dbwc_walls.sv
// Wall builder: right and bottom edges, gap ends and the mask of wall pieces
// long enough to count. Combinational; depends on dbwc_pkg.
`default_nettype none

module dbwc_walls
  import dbwc_pkg::*;
(
  input  dbwc_cfg_t            cfg_i,
  input  logic signed [CW-1:0] centre_i,
  output dbwc_geom_t           geom_o
);

  localparam logic signed [CW-1:0] MinLen = CW'(MIN_WALL_LEN);

  logic signed [CW-1:0] x, y, w, h, xr, yb, half;
  logic signed [CW-1:0] start, stop, lo_c, hi_c, gmin, gmax, len_a, len_b;
  logic                 horiz;
  logic                 ok_a, ok_b, ok_w, ok_h;
  logic [7:0]           mask;

  always_comb begin
    x     = CW'(cfg_i.box_left);
    y     = CW'(cfg_i.box_top);
    w     = CW'(cfg_i.box_width);
    h     = CW'(cfg_i.box_height);
    xr    = x + w;
    yb    = y + h;
    half  = $signed(CW'(cfg_i.gap_width >> 1));
    horiz = (cfg_i.gap_side == {1'b0, SIDE_TOP}) || (cfg_i.gap_side == {1'b0, SIDE_BOTTOM});
    start = horiz ? x : y;
    stop  = horiz ? xr : yb;
    lo_c  = centre_i - half;
    hi_c  = centre_i + half;
    gmin  = (lo_c > start) ? lo_c : start;
    gmax  = (hi_c < stop) ? hi_c : stop;
    len_a = gmin - start;
    len_b = stop - gmax;
    ok_a  = len_a >= MinLen;
    ok_b  = len_b >= MinLen;
    ok_w  = w >= MinLen;
    ok_h  = h >= MinLen;

    mask = 8'b0;
    case (cfg_i.gap_side)
      {1'b0, SIDE_TOP}:    mask = {1'b0, ok_h, 1'b0, ok_h, 1'b0, ok_w, ok_b, ok_a};
      {1'b0, SIDE_BOTTOM}: mask = {1'b0, ok_h, 1'b0, ok_h, ok_b, ok_a, 1'b0, ok_w};
      {1'b0, SIDE_LEFT}:   mask = {1'b0, ok_h, ok_b, ok_a, 1'b0, ok_w, 1'b0, ok_w};
      {1'b0, SIDE_RIGHT}:  mask = {ok_b, ok_a, 1'b0, ok_h, 1'b0, ok_w, 1'b0, ok_w};
      default:             mask = {1'b0, ok_h, 1'b0, ok_h, 1'b0, ok_w, 1'b0, ok_w};
    endcase

    geom_o.xr   = xr;
    geom_o.yb   = yb;
    geom_o.gmin = gmin;
    geom_o.gmax = gmax;
    geom_o.mask = mask;
  end

endmodule

`default_nettype wire

>>> src/dbwc_root_div.sv
// Iterative unit: floored square root of a 64-bit value (two bits a cycle)
// or a Q1.15 quotient num*32768/den with num <= den (one bit a cycle).
// Both share one 64-bit subtract/compare. Depends on dbwc_pkg.
`default_nettype none

module dbwc_root_div
  import dbwc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dbwc_ctl_t   ctl_i,
  input  logic [63:0] rad_i,
  input  logic [31:0] num_i,
  input  logic [30:0] den_i,
  output dbwc_stat_t  stat_o,
  output logic [31:0] root_o,
  output logic [16:0] quot_o
);

  logic        busy_q, done_q, div_q;
  logic [4:0]  cnt_q;
  logic [63:0] acc_q, res_q;
  logic [30:0] den_q;

  logic [5:0]  sh;
  logic [63:0] bitv, op_a, op_b;
  logic [64:0] diff;
  logic        ge, last;

  always_comb begin
    sh   = 6'd62 - {cnt_q, 1'b0};
    bitv = 64'd1 << sh;
    if (div_q) begin
      // first step takes the integer bit of the quotient without a shift
      op_a = (cnt_q == 5'd0) ? acc_q : {acc_q[62:0], 1'b0};
      op_b = 64'(den_q);
    end else begin
      op_a = acc_q;
      op_b = res_q + bitv;
    end
    diff = {1'b0, op_a} - {1'b0, op_b};
    ge   = !diff[64];
    last = div_q ? (cnt_q == 5'd15) : (cnt_q == 5'd31);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      div_q  <= 1'b0;
      cnt_q  <= 5'd0;
      acc_q  <= 64'd0;
      res_q  <= 64'd0;
      den_q  <= 31'd0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        div_q  <= ctl_i.div;
        cnt_q  <= 5'd0;
        acc_q  <= ctl_i.div ? 64'(num_i) : rad_i;
        res_q  <= 64'd0;
        den_q  <= den_i;
      end else if (busy_q) begin
        if (div_q) begin
          acc_q <= ge ? diff[63:0] : op_a;
          res_q <= {res_q[62:0], ge};
        end else begin
          acc_q <= ge ? diff[63:0] : acc_q;
          res_q <= ge ? ((res_q >> 1) + bitv) : (res_q >> 1);
        end
        cnt_q <= cnt_q + 5'd1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign root_o      = res_q[31:0];
  assign quot_o      = res_q[16:0];

endmodule

`default_nettype wire

>>> src/disc_box_wall_collision.sv
// Disc against box walls: resolves a moving disc against up to five wall
// pieces of an axis-aligned box with an optional entrance gap. One word is
// taken at a time; in_ready_o is high only while the block is idle, and a
// finished result waits in the output register while the next word is taken.
// For each pass the block visits eight wall slots. A contact uses the
// 32-step square root and two 16-step divides of the shared root/divide
// unit (no divides when the centre lies on the wall), plus 11 products on
// the one shared multiplier after the three of the distance test. The walls
// are built first; up to PASS_MAX passes, and a disabled box returns without a pass.
// Depends on dbwc_pkg, dbwc_walls and dbwc_root_div.
`default_nettype none

module disc_box_wall_collision
  import dbwc_pkg::*;
#(
  parameter int PASS_MAX      = 4,
  parameter int TANGENT_DAMP  = 29491,
  parameter int SAFETY_MARGIN = 65
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [30:0]        disc_radius_i,
  input  logic signed [31:0] in_pos_x_i,
  input  logic signed [31:0] in_pos_y_i,
  input  logic signed [31:0] in_vel_x_i,
  input  logic signed [31:0] in_vel_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_pos_x_o,
  output logic signed [31:0] out_pos_y_o,
  output logic signed [31:0] out_vel_x_o,
  output logic signed [31:0] out_vel_y_o,
  output logic               hit_any_o
);

  localparam int IW = (PASS_MAX > 1) ? $clog2(PASS_MAX) : 1;
  localparam int PW = CW + 32;
  localparam logic signed [31:0] TDamp  = 32'(TANGENT_DAMP);
  localparam logic signed [33:0] Margin = 34'(SAFETY_MARGIN);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_MUL_USE, S_BUILD, S_WALL, S_ROOT_GO, S_ROOT_WAIT,
    S_DIVX_GO, S_DIVX_WAIT, S_DIVY_GO, S_DIVY_WAIT, S_NEXT, S_DONE
  } state_e;

  typedef enum logic [3:0] {
    MS_CENTRE, MS_RXSQ, MS_RYSQ, MS_RSQ, MS_PX, MS_PY, MS_VN_X, MS_VN_Y,
    MS_TX, MS_TY, MS_NVN, MS_VXN, MS_VX, MS_VYN, MS_VY
  } mstep_e;

  // configuration registers
  logic signed [31:0] box_left_q, box_top_q, box_width_q, box_height_q;
  logic [2:0]         gap_side_q;
  logic [16:0]        gap_position_q;
  logic [30:0]        gap_width_q;
  logic [15:0]        bounce_q;

  state_e               state_q;
  mstep_e               mstep_q;
  logic [IW-1:0]        iter_q;
  logic [2:0]           idx_q;
  logic                 hit_pass_q, any_q;
  logic [30:0]          r_q, dist_q;
  logic signed [31:0]   px_q, py_q, vx_q, vy_q, rx_q, ry_q;
  logic signed [CW-1:0] centre_q, xr_q, yb_q, gmin_q, gmax_q;
  logic [7:0]           mask_q;
  logic [63:0]          dsq_q;
  logic signed [33:0]   pen_q;
  logic signed [16:0]   nx_q, ny_q;
  logic signed [VW-1:0] vn_q, tx_q, ty_q, nvn_q, acc_q;
  logic signed [PW-1:0] prod_q;
  logic                 out_valid_q, hit_any_q;
  logic signed [31:0]   out_px_q, out_py_q, out_vx_q, out_vy_q;

  dbwc_cfg_t  cfg;
  dbwc_geom_t geom;
  dbwc_ctl_t  rd_ctl;
  dbwc_stat_t rd_stat;
  logic [31:0] rd_root, rd_num;
  logic [16:0] rd_quot;

  // wall segment for the current slot
  logic [1:0]           seg_side;
  logic                 seg_gap, seg_horiz;
  logic signed [CW-1:0] x_e, y_e, seg_lo, seg_hi, seg_fix, seg_start, seg_stop;
  logic signed [CW-1:0] along, clamped;
  logic signed [CW:0]   rx_w, ry_w, r_e;
  logic                 near;
  logic                 enabled, gap_horiz;

  logic signed [CW-1:0] mul_a;
  logic signed [31:0]   mul_b;
  logic signed [PW-1:0] prod_adj;
  logic signed [VW-1:0] q15;
  logic [31:0]          abs_rx, abs_ry;
  logic signed [16:0]   qsig;

  function automatic logic signed [31:0] sat32(input logic signed [VW-1:0] v);
    if ((&v[VW-1:31]) || !(|v[VW-1:31])) begin
      return v[31:0];
    end
    return v[VW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  function automatic logic signed [16:0] wall_nx(input logic [1:0] s);
    case (s)
      SIDE_LEFT:  return -17'(Q15_ONE);
      SIDE_RIGHT: return 17'(Q15_ONE);
      default:    return 17'sd0;
    endcase
  endfunction

  function automatic logic signed [16:0] wall_ny(input logic [1:0] s);
    case (s)
      SIDE_TOP:    return -17'(Q15_ONE);
      SIDE_BOTTOM: return 17'(Q15_ONE);
      default:     return 17'sd0;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // configuration port
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_left_q     <= 32'sd0;
      box_top_q      <= 32'sd0;
      box_width_q    <= 32'sd0;
      box_height_q   <= 32'sd0;
      gap_side_q     <= GAP_SIDE_RST;
      gap_position_q <= GAP_POS_RST;
      gap_width_q    <= 31'd0;
      bounce_q       <= BOUNCE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_BOX_LEFT:   box_left_q     <= cfg_data_i;
        REG_BOX_TOP:    box_top_q      <= cfg_data_i;
        REG_BOX_WIDTH:  box_width_q    <= cfg_data_i;
        REG_BOX_HEIGHT: box_height_q   <= cfg_data_i;
        REG_GAP_SIDE:   gap_side_q     <= cfg_data_i[2:0];
        REG_GAP_POS:    gap_position_q <= cfg_data_i[16:0];
        REG_GAP_WIDTH:  gap_width_q    <= cfg_data_i[30:0];
        REG_BOUNCE:     bounce_q       <= cfg_data_i[15:0];
      endcase
    end
  end

  assign cfg.box_left     = box_left_q;
  assign cfg.box_top      = box_top_q;
  assign cfg.box_width    = box_width_q;
  assign cfg.box_height   = box_height_q;
  assign cfg.gap_side     = gap_side_q;
  assign cfg.gap_position = gap_position_q;
  assign cfg.gap_width    = gap_width_q;

  dbwc_walls u_walls (
    .cfg_i    (cfg),
    .centre_i (centre_q),
    .geom_o   (geom)
  );

  // ---------------------------------------------------------------------
  // segment select, clamp and bounding-box test
  always_comb begin
    enabled   = (box_width_q > 32'sd0) && (box_height_q > 32'sd0);
    gap_horiz = (gap_side_q == {1'b0, SIDE_TOP}) || (gap_side_q == {1'b0, SIDE_BOTTOM});
    x_e       = CW'(box_left_q);
    y_e       = CW'(box_top_q);
    seg_side  = idx_q[2:1];
    seg_gap   = (gap_side_q == {1'b0, seg_side});
    seg_horiz = !seg_side[1];
    seg_start = seg_horiz ? x_e : y_e;
    seg_stop  = seg_horiz ? xr_q : yb_q;
    seg_lo    = (seg_gap && idx_q[0]) ? gmax_q : seg_start;
    seg_hi    = (seg_gap && !idx_q[0]) ? gmin_q : seg_stop;
    case (seg_side)
      SIDE_TOP:    seg_fix = y_e;
      SIDE_BOTTOM: seg_fix = yb_q;
      SIDE_LEFT:   seg_fix = x_e;
      default:     seg_fix = xr_q;
    endcase
    along   = seg_horiz ? CW'(px_q) : CW'(py_q);
    clamped = (along < seg_lo) ? seg_lo : ((along > seg_hi) ? seg_hi : along);
    rx_w    = (CW + 1)'(px_q) - (CW + 1)'(seg_horiz ? clamped : seg_fix);
    ry_w    = (CW + 1)'(py_q) - (CW + 1)'(seg_horiz ? seg_fix : clamped);
    r_e     = $signed((CW + 1)'(r_q));
    near    = (rx_w < r_e) && (rx_w > -r_e) && (ry_w < r_e) && (ry_w > -r_e);
  end

  // ---------------------------------------------------------------------
  // shared multiplier, product registered
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (mstep_q)
      MS_CENTRE: begin
        mul_a = gap_horiz ? CW'(box_width_q) : CW'(box_height_q);
        mul_b = $signed(32'(gap_position_q));
      end
      MS_RXSQ: begin mul_a = CW'(rx_q);         mul_b = rx_q;               end
      MS_RYSQ: begin mul_a = CW'(ry_q);         mul_b = ry_q;               end
      MS_RSQ:  begin mul_a = $signed(CW'(r_q)); mul_b = $signed(32'(r_q));  end
      MS_PX:   begin mul_a = CW'(pen_q);        mul_b = 32'(nx_q);          end
      MS_PY:   begin mul_a = CW'(pen_q);        mul_b = 32'(ny_q);          end
      MS_VN_X: begin mul_a = CW'(vx_q);         mul_b = 32'(nx_q);          end
      MS_VN_Y: begin mul_a = CW'(vy_q);         mul_b = 32'(ny_q);          end
      MS_TX:   begin mul_a = CW'(vn_q);         mul_b = 32'(nx_q);          end
      MS_TY:   begin mul_a = CW'(vn_q);         mul_b = 32'(ny_q);          end
      MS_NVN:  begin mul_a = CW'(vn_q);         mul_b = $signed(32'(bounce_q)); end
      MS_VXN:  begin mul_a = CW'(nvn_q);        mul_b = 32'(nx_q);          end
      MS_VX:   begin mul_a = CW'(tx_q);         mul_b = TDamp;              end
      MS_VYN:  begin mul_a = CW'(nvn_q);        mul_b = 32'(ny_q);          end
      MS_VY:   begin mul_a = CW'(ty_q);         mul_b = TDamp;              end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Q1.15 scaling, truncated toward zero
  always_comb begin
    prod_adj = prod_q + (prod_q[PW-1] ? PW'(32767) : PW'(0));
    q15      = VW'(prod_adj >>> 15);
    abs_rx   = rx_q[31] ? 32'(-rx_q) : 32'(rx_q);
    abs_ry   = ry_q[31] ? 32'(-ry_q) : 32'(ry_q);
    rd_num   = (state_q == S_DIVY_GO) ? abs_ry : abs_rx;
    rd_ctl.start = (state_q == S_ROOT_GO) || (state_q == S_DIVX_GO) || (state_q == S_DIVY_GO);
    rd_ctl.div   = (state_q != S_ROOT_GO);
    qsig     = $signed(rd_quot);
  end

  dbwc_root_div u_root_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (rd_ctl),
    .rad_i  (dsq_q),
    .num_i  (rd_num),
    .den_i  (dist_q),
    .stat_o (rd_stat),
    .root_o (rd_root),
    .quot_o (rd_quot)
  );

  // ---------------------------------------------------------------------
  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mstep_q     <= MS_CENTRE;
      iter_q      <= '0;
      idx_q       <= 3'd0;
      hit_pass_q  <= 1'b0;
      any_q       <= 1'b0;
      r_q         <= '0;
      dist_q      <= '0;
      px_q        <= '0;
      py_q        <= '0;
      vx_q        <= '0;
      vy_q        <= '0;
      rx_q        <= '0;
      ry_q        <= '0;
      centre_q    <= '0;
      xr_q        <= '0;
      yb_q        <= '0;
      gmin_q      <= '0;
      gmax_q      <= '0;
      mask_q      <= '0;
      dsq_q       <= '0;
      pen_q       <= '0;
      nx_q        <= '0;
      ny_q        <= '0;
      vn_q        <= '0;
      tx_q        <= '0;
      ty_q        <= '0;
      nvn_q       <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      hit_any_q   <= 1'b0;
      out_px_q    <= '0;
      out_py_q    <= '0;
      out_vx_q    <= '0;
      out_vy_q    <= '0;
    end else begin
      if ((state_q == S_DONE) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            r_q        <= disc_radius_i;
            px_q       <= in_pos_x_i;
            py_q       <= in_pos_y_i;
            vx_q       <= in_vel_x_i;
            vy_q       <= in_vel_y_i;
            any_q      <= 1'b0;
            hit_pass_q <= 1'b0;
            iter_q     <= '0;
            idx_q      <= 3'd0;
            mstep_q    <= MS_CENTRE;
            state_q    <= enabled ? S_MUL : S_DONE;
          end
        end
        S_MUL: state_q <= S_MUL_USE;
        S_MUL_USE: begin
          state_q <= S_MUL;
          unique case (mstep_q)
            MS_CENTRE: begin
              centre_q <= (gap_horiz ? x_e : y_e) + $signed(CW'(prod_q[47:16]));
              state_q  <= S_BUILD;
            end
            MS_RXSQ: begin
              dsq_q   <= prod_q[63:0];
              mstep_q <= MS_RYSQ;
            end
            MS_RYSQ: begin
              dsq_q   <= dsq_q + prod_q[63:0];
              mstep_q <= MS_RSQ;
            end
            MS_RSQ:  state_q <= (dsq_q < prod_q[63:0]) ? S_ROOT_GO : S_NEXT;
            MS_PX: begin
              px_q    <= sat32(VW'(px_q) + q15);
              mstep_q <= MS_PY;
            end
            MS_PY: begin
              py_q    <= sat32(VW'(py_q) + q15);
              mstep_q <= MS_VN_X;
            end
            MS_VN_X: begin
              vn_q    <= q15;
              mstep_q <= MS_VN_Y;
            end
            MS_VN_Y: begin
              vn_q    <= vn_q + q15;
              mstep_q <= MS_TX;
            end
            MS_TX: begin
              tx_q    <= VW'(vx_q) - q15;
              mstep_q <= MS_TY;
            end
            MS_TY: begin
              ty_q    <= VW'(vy_q) - q15;
              mstep_q <= MS_NVN;
            end
            MS_NVN: begin
              nvn_q   <= -q15;
              mstep_q <= MS_VXN;
            end
            MS_VXN: begin
              acc_q   <= q15;
              mstep_q <= MS_VX;
            end
            MS_VX: begin
              vx_q    <= sat32(acc_q + q15);
              mstep_q <= MS_VYN;
            end
            MS_VYN: begin
              acc_q   <= q15;
              mstep_q <= MS_VY;
            end
            MS_VY: begin
              vy_q       <= sat32(acc_q + q15);
              hit_pass_q <= 1'b1;
              any_q      <= 1'b1;
              state_q    <= S_NEXT;
            end
          endcase
        end
        S_BUILD: begin
          xr_q    <= geom.xr;
          yb_q    <= geom.yb;
          gmin_q  <= geom.gmin;
          gmax_q  <= geom.gmax;
          mask_q  <= geom.mask;
          state_q <= S_WALL;
        end
        S_WALL: begin
          if (mask_q[idx_q] && near) begin
            // inside the radius box, so both offsets fit 32 bits
            rx_q    <= rx_w[31:0];
            ry_q    <= ry_w[31:0];
            mstep_q <= MS_RXSQ;
            state_q <= S_MUL;
          end else begin
            state_q <= S_NEXT;
          end
        end
        S_ROOT_GO: state_q <= S_ROOT_WAIT;
        S_ROOT_WAIT: begin
          if (rd_stat.done) begin
            dist_q <= rd_root[30:0];
            pen_q  <= $signed(34'(r_q)) - $signed(34'(rd_root[30:0])) + Margin;
            if (dsq_q == 64'd0) begin
              // centre on the wall: take the outward normal
              nx_q    <= wall_nx(seg_side);
              ny_q    <= wall_ny(seg_side);
              mstep_q <= MS_PX;
              state_q <= S_MUL;
            end else begin
              state_q <= S_DIVX_GO;
            end
          end
        end
        S_DIVX_GO: state_q <= S_DIVX_WAIT;
        S_DIVX_WAIT: begin
          if (rd_stat.done) begin
            nx_q    <= rx_q[31] ? -qsig : qsig;
            state_q <= S_DIVY_GO;
          end
        end
        S_DIVY_GO: state_q <= S_DIVY_WAIT;
        S_DIVY_WAIT: begin
          if (rd_stat.done) begin
            ny_q    <= ry_q[31] ? -qsig : qsig;
            mstep_q <= MS_PX;
            state_q <= S_MUL;
          end
        end
        S_NEXT: begin
          if (idx_q == 3'd7) begin
            idx_q <= 3'd0;
            if (!hit_pass_q || (iter_q == IW'(PASS_MAX - 1))) begin
              state_q <= S_DONE;
            end else begin
              iter_q     <= iter_q + 1'b1;
              hit_pass_q <= 1'b0;
              state_q    <= S_WALL;
            end
          end else begin
            idx_q   <= idx_q + 3'd1;
            state_q <= S_WALL;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_px_q    <= px_q;
            out_py_q    <= py_q;
            out_vx_q    <= vx_q;
            out_vy_q    <= vy_q;
            hit_any_q   <= any_q;
            state_q     <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_pos_x_o = out_px_q;
  assign out_pos_y_o = out_py_q;
  assign out_vel_x_o = out_vx_q;
  assign out_vel_y_o = out_vy_q;
  assign hit_any_o   = hit_any_q;

endmodule

`default_nettype wire

>>> src/dbwc_checker.sv
// Port-level checks for disc_box_wall_collision, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module dbwc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [2:0]         cfg_index_i,
  input logic [31:0]        cfg_data_i,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [30:0]        disc_radius_i,
  input logic signed [31:0] in_pos_x_i,
  input logic signed [31:0] in_pos_y_i,
  input logic signed [31:0] in_vel_x_i,
  input logic signed [31:0] in_vel_y_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] out_pos_x_o,
  input logic signed [31:0] out_pos_y_o,
  input logic signed [31:0] out_vel_x_o,
  input logic signed [31:0] out_vel_y_o,
  input logic               hit_any_o
);

  // a taken word makes in_ready_o low in the cycle after it is taken
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("in_ready high right after a word was taken");

  // the block turns ready again only when it posts a result
  a_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_o) |-> out_valid_o)
    else $error("block went idle without a result word");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_pos_x_o)
      && $stable(out_pos_y_o) && $stable(out_vel_x_o) && $stable(out_vel_y_o)
      && $stable(hit_any_o))
    else $error("stalled result word changed");

endmodule

bind disc_box_wall_collision dbwc_checker u_dbwc_checker (.*);

`default_nettype wire

>>> tb/disc_box_wall_collision_tb.sv
// Testbench for disc_box_wall_collision: drives disc words and register writes,
// predicts each result with a local fixed-point wall solver, checks in order.
// Depends on dbwc_pkg and the disc_box_wall_collision RTL.
`default_nettype none

module disc_box_wall_collision_tb;
  import dbwc_pkg::*;

  localparam int unsigned ITERS  = 4;
  localparam longint      DAMP   = 29491;
  localparam longint      MARGIN = 65;
  localparam longint      ONE    = 32768;
  localparam longint      MINLEN = 66;

  typedef struct {
    logic signed [31:0] px, py, vx, vy;
    logic               hit;
  } disc_res_t;

  typedef struct {
    longint ax, ay, bx, by, nx, ny;
  } seg_t;

  int errors = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  class disc_scoreboard;
    // register shadow
    longint   left, top, wid, hgt;
    bit [2:0] side;
    longint   gpos, gwid, bounce;
    disc_res_t pending[$];
    seg_t     segs[$];

    function new();
      left = 0; top = 0; wid = 0; hgt = 0;
      side = GAP_SIDE_RST; gpos = GAP_POS_RST; gwid = 0; bounce = BOUNCE_RST;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [31:0] d);
      case (idx)
        REG_BOX_LEFT:   left = longint'(signed'(d));
        REG_BOX_TOP:    top  = longint'(signed'(d));
        REG_BOX_WIDTH:  wid  = longint'(signed'(d));
        REG_BOX_HEIGHT: hgt  = longint'(signed'(d));
        REG_GAP_SIDE:   side = d[2:0];
        REG_GAP_POS:    gpos = d[16:0];
        REG_GAP_WIDTH:  gwid = d[30:0];
        REG_BOUNCE:     bounce = d[15:0];
      endcase
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint fmul(longint a, longint f);
      return (a * f) / ONE;
    endfunction

    function longint root(longint unsigned n);
      longint unsigned res, b;
      res = 0; b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else res >>= 1;
        b >>= 2;
      end
      return longint'(res);
    endfunction

    function void add_seg(longint ax, longint ay, longint bx, longint by,
                          longint nx, longint ny);
      seg_t s;
      longint dx, dy;
      dx = bx - ax; dy = by - ay;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      if (dx + dy < MINLEN || segs.size() >= 5) return;
      s.ax = ax; s.ay = ay; s.bx = bx; s.by = by; s.nx = nx; s.ny = ny;
      segs.push_back(s);
    endfunction

    function void build();
      longint xr, yb, half, c, gmin, gmax;
      xr = left + wid; yb = top + hgt; half = gwid >>> 1;
      segs.delete();
      if (side == SIDE_TOP || side == SIDE_BOTTOM) begin
        c = left + ((gpos * wid) >>> 16);
        gmin = (c - half > left) ? c - half : left;
        gmax = (c + half < xr) ? c + half : xr;
      end else begin
        c = top + ((gpos * hgt) >>> 16);
        gmin = (c - half > top) ? c - half : top;
        gmax = (c + half < yb) ? c + half : yb;
      end
      if (side == SIDE_TOP) begin
        if (gmin > left) add_seg(left, top, gmin, top, 0, -ONE);
        if (gmax < xr) add_seg(gmax, top, xr, top, 0, -ONE);
      end else add_seg(left, top, xr, top, 0, -ONE);
      if (side == SIDE_BOTTOM) begin
        if (gmin > left) add_seg(left, yb, gmin, yb, 0, ONE);
        if (gmax < xr) add_seg(gmax, yb, xr, yb, 0, ONE);
      end else add_seg(left, yb, xr, yb, 0, ONE);
      if (side == SIDE_LEFT) begin
        if (gmin > top) add_seg(left, top, left, gmin, -ONE, 0);
        if (gmax < yb) add_seg(left, gmax, left, yb, -ONE, 0);
      end else add_seg(left, top, left, yb, -ONE, 0);
      if (side == SIDE_RIGHT) begin
        if (gmin > top) add_seg(xr, top, xr, gmin, ONE, 0);
        if (gmax < yb) add_seg(xr, gmax, xr, yb, ONE, 0);
      end else add_seg(xr, top, xr, yb, ONE, 0);
    endfunction

    function longint clampv(longint v, longint a, longint b);
      longint lo, hi;
      lo = a < b ? a : b; hi = a < b ? b : a;
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function bit push_out(seg_t s, longint r, inout longint px, inout longint py,
                          inout longint vx, inout longint vy);
      longint rx, ry, nx, ny, dlen, pen, vn, tx, ty, nvn;
      longint unsigned dsq;
      rx = px - clampv(px, s.ax, s.bx);
      ry = py - clampv(py, s.ay, s.by);
      if (rx >= r || -rx >= r || ry >= r || -ry >= r) return 0;
      dsq = longint'(rx * rx) + longint'(ry * ry);
      if (dsq >= longint'(r * r)) return 0;
      dlen = root(dsq);
      if (dsq == 0) begin
        nx = s.nx; ny = s.ny;
      end else begin
        nx = (rx * ONE) / dlen; ny = (ry * ONE) / dlen;
      end
      pen = r - dlen + MARGIN;
      px = sat(px + fmul(pen, nx));
      py = sat(py + fmul(pen, ny));
      vn = fmul(vx, nx) + fmul(vy, ny);
      tx = vx - fmul(vn, nx);
      ty = vy - fmul(vn, ny);
      nvn = -fmul(vn, bounce);
      vx = sat(fmul(nvn, nx) + fmul(tx, DAMP));
      vy = sat(fmul(nvn, ny) + fmul(ty, DAMP));
      return 1;
    endfunction

    function void note_disc(logic [30:0] rad, logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] u, logic signed [31:0] v);
      disc_res_t e;
      longint r, px, py, vx, vy;
      bit any, hit;
      r = rad; px = x; py = y; vx = u; vy = v; any = 0;
      if (wid > 0 && hgt > 0) begin
        build();
        for (int it = 0; it < ITERS; it++) begin
          hit = 0;
          foreach (segs[i]) hit |= push_out(segs[i], r, px, py, vx, vy);
          any |= hit;
          if (!hit) break;
        end
      end
      e.px = px[31:0]; e.py = py[31:0]; e.vx = vx[31:0]; e.vy = vy[31:0]; e.hit = any;
      pending.push_back(e);
    endfunction

    task check_result(logic signed [31:0] px, logic signed [31:0] py,
                      logic signed [31:0] vx, logic signed [31:0] vy, logic hit);
      disc_res_t e;
      if (pending.size() == 0) begin
        report("unexpected word", 0, 0);
        return;
      end
      e = pending.pop_front();
      if (px !== e.px) report("out_pos_x", px, e.px);
      if (py !== e.py) report("out_pos_y", py, e.py);
      if (vx !== e.vx) report("out_vel_x", vx, e.vx);
      if (vy !== e.vy) report("out_vel_y", vy, e.vy);
      if (hit !== e.hit) report("hit_any", hit, e.hit);
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic cfg_valid = 0, in_valid = 0, out_ready = 0;
  logic cfg_ready, in_ready, out_valid;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic [30:0] radius = '0;
  logic signed [31:0] ipx = '0, ipy = '0, ivx = '0, ivy = '0;
  logic signed [31:0] opx, opy, ovx, ovy;
  logic hit_any;
  bit long_hold = 0;

  disc_scoreboard sb = new();

  disc_box_wall_collision dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .disc_radius_i(radius), .in_pos_x_i(ipx), .in_pos_y_i(ipy),
    .in_vel_x_i(ivx), .in_vel_y_i(ivy),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .out_pos_x_o(opx), .out_pos_y_o(opy), .out_vel_x_o(ovx), .out_vel_y_o(ovy),
    .hit_any_o(hit_any)
  );

  initial forever #5 clk = ~clk;

  task automatic write_reg(cfg_reg_e idx, logic [31:0] d);
    @(negedge clk);
    cfg_index <= idx; cfg_data <= d; cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic send_disc(logic [30:0] r, logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] u, logic signed [31:0] v, bit gaps);
    @(negedge clk);
    if (gaps) repeat ($urandom_range(0, 19)) @(negedge clk);
    radius <= r; ipx <= x; ipy <= y; ivx <= u; ivy <= v; in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    sb.note_disc(r, x, y, u, v);
    @(negedge clk);
    in_valid <= 0;
  endtask

  // box: left, top, width, height
  task automatic set_box(int l, int t, int w, int h);
    write_reg(REG_BOX_LEFT, l);
    write_reg(REG_BOX_TOP, t);
    write_reg(REG_BOX_WIDTH, w);
    write_reg(REG_BOX_HEIGHT, h);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (2000) @(negedge clk);
  endtask

  // receiver: random stall per word, one long hold-off on request
  initial begin
    int unsigned n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 0;
        repeat (3000) @(negedge clk);
        long_hold = 0;
      end
      n = $urandom_range(0, 19);
      if (n != 0) begin
        out_ready <= 0;
        repeat (n) @(negedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && out_ready) sb.check_result(opx, opy, ovx, ovy, hit_any);

  // random disc near the box so that most words touch a wall
  task automatic random_disc(int l, int t, int w, int h, bit gaps);
    int r, x, y;
    r = (w / 16 > 2) ? $urandom_range(0, w / 16) : $urandom_range(0, 5000);
    if ($urandom_range(0, 15) == 0) r = $urandom;
    x = l + $signed($urandom_range(0, w + 2 * r)) - r;
    y = t + $signed($urandom_range(0, h + 2 * r)) - r;
    if ($urandom_range(0, 3) == 0) x = (l + $signed($urandom_range(0, 1)) * w);
    if ($urandom_range(0, 3) == 0) y = (t + $signed($urandom_range(0, 1)) * h);
    if ($urandom_range(0, 20) == 0) begin
      x = $urandom; y = $urandom;
    end
    send_disc(r, x, y, $urandom, $urandom, gaps);
  endtask

  initial begin
    int l, t, w, h;
    repeat (8) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // reset registers: box disabled, disc passes through
    send_disc('1, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 0);
    drain();

    // directed: closed box at origin, 10 x 8 units
    set_box(0, 0, 10 << 16, 8 << 16);
    send_disc(1 << 16, 0, 4 << 16, 3 << 16, -(1 << 16), 0);   // centre on the wall
    send_disc(0, 0, 0, 1, 1, 0);                              // zero radius
    send_disc(1 << 16, 5 << 16, 32768, -(5 << 16), -(7 << 16), 0);
    send_disc(1 << 16, 32768, 32768, 5 << 16, 5 << 16, 0);    // corner, several passes
    send_disc(3 << 16, 5 << 16, 4 << 16, 1 << 16, 2 << 16, 0);
    send_disc('1, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0);
    drain();
    // gap on each side, gap position above one, bounce above one
    write_reg(REG_BOUNCE, 16'hffff);
    write_reg(REG_GAP_WIDTH, 4 << 16);
    for (int s = 0; s < 8; s++) begin
      write_reg(REG_GAP_SIDE, s);
      write_reg(REG_GAP_POS, (s == 5) ? 17'h1ffff : (s == 6 ? 0 : 17'd32768));
      send_disc(1 << 16, 5 << 16, 0, 1 << 16, -(2 << 16), 0);
      send_disc(1 << 16, 0, 4 << 16, -(2 << 16), 1 << 16, 0);
      drain();
    end
    // short wall pieces: gap over the whole top wall, then a gap leaving 40 raw units
    write_reg(REG_GAP_SIDE, SIDE_TOP);
    write_reg(REG_GAP_POS, 0);
    write_reg(REG_GAP_WIDTH, 31'h7fffffff);
    send_disc(1 << 16, 1 << 16, 0, 0, -(1 << 16), 0);
    drain();
    write_reg(REG_GAP_POS, 32768);
    set_box(0, 0, 10 << 16, 8 << 16);
    drain();
    write_reg(REG_GAP_WIDTH, (10 << 16) - 80);
    send_disc(1 << 16, 10 << 16, 0, 1 << 16, 1 << 16, 0);
    drain();

    // random phases over several settings, extremes among them
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: begin l = 0; t = 0; w = 10 << 16; h = 8 << 16; end
        1: begin l = -(1000 << 16); t = 500 << 16; w = 200 << 16; h = 100 << 16; end
        2: begin l = 32'sh80000000; t = 32'sh80000000; w = 32'sh7fffffff; h = 32'sh7fffffff; end
        3: begin l = 32'sh7fff0000; t = 32'sh7fff0000; w = 1 << 20; h = 1 << 20; end
        4: begin l = 0; t = 0; w = 0; h = 5 << 16; end
        5: begin l = 0; t = 0; w = 5 << 16; h = 32'sh80000000; end
        default: begin
          l = $urandom; t = $urandom; w = $urandom_range(100, 1 << 24);
          h = $urandom_range(100, 1 << 24);
        end
      endcase
      set_box(l, t, w, h);
      write_reg(REG_GAP_SIDE, $urandom_range(0, 7));
      write_reg(REG_GAP_POS, (ph == 2) ? 17'h10000 : $urandom_range(0, 17'h1ffff));
      write_reg(REG_GAP_WIDTH, (ph == 3) ? 0 : $urandom_range(0, 31'h7fffffff) >> $urandom_range(0, 30));
      write_reg(REG_BOUNCE, (ph == 1) ? 0 : (ph == 2 ? 32768 : $urandom_range(0, 16'hffff)));
      if (ph == 4) long_hold = 1;
      for (int k = 0; k < 95; k++) random_disc(l, t, w, h, (ph != 4) && (k % 30 > 4));
      drain();
    end

    if (errors == 0)
      $display("** disc_box_wall_collision: PASSED **");
    else
      $display("** disc_box_wall_collision: FAILED **");
    $finish;
  end

  initial begin
    #200000000;
    $display("** disc_box_wall_collision: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
src/dbwc_pkg.sv
src/dbwc_walls.sv
src/dbwc_root_div.sv
src/disc_box_wall_collision.sv
src/dbwc_checker.sv
tb/disc_box_wall_collision_tb.sv
